// ===== sv/rkbc_pkg.sv =====
// Shared constants, register codes and control types for the running-key byte cipher.
`timescale 1ns / 1ps

package rkbc_pkg;

    localparam int KEY_MAX_BYTES = 32;
    localparam int DATA_W        = 8;
    localparam int POS_W         = 5;
    localparam int LEN_W         = 6;
    localparam int KEY_WORD_W    = 64;
    localparam int KEY_WORDS     = 4;
    localparam int SUM_W         = 13;
    localparam int BIT_W         = 4;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUMULATIVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0_7    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_8_15   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_16_23  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_24_31  = 3'd6;

    typedef struct packed {
        logic latch_in;
        logic step;
        logic src_latched;
        logic sum_en;
        logic mod_init;
        logic mod_en;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic sum_last;
        logic mod_last;
        logic out_free;
    } t_status;

endpackage

// ===== sv/running_key_byte_cipher_unit.sv =====
// Top level of the running-key byte cipher: controller and datapath.
`timescale 1ns / 1ps

// A byte without the start flag, or any byte while the key length is zero, is accepted
// and its result sits in the output register on the next cycle, and the next byte can
// be accepted in the cycle that result is taken downstream. A byte with the start flag
// and a nonzero key length, N the active key length, passes through the accepting
// cycle, a sum of the N key bytes through the single key byte select, a bit-serial
// remainder of that sum by N, and the processing of the byte once the output register
// is free; no byte is accepted meanwhile.
// Configuration writes are always taken and must only be issued while the block is idle.

module running_key_byte_cipher_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [7:0]                           i_s_tdata,   // [7:0] data_in
    input  logic                                 i_s_tuser,   // [0] start_of_stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [7:0]                           o_m_tdata,   // [7:0] data_out
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rkbc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rkbc_pkg::KEY_WORD_W-1:0]      i_cfg_data
);

    rkbc_pkg::t_cmd    w_cmd;
    rkbc_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    rkbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rkbc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_data      (i_s_tdata),
        .i_start     (i_s_tuser),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule

// ===== sv/rkbc_ctrl.sv =====
// Controller state machine: request intake, key sum sweep and remainder iteration.
`timescale 1ns / 1ps

module rkbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tuser,
    output logic              o_s_tready,
    input  rkbc_pkg::t_status i_status,
    output rkbc_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_MOD,
        S_PROC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_s_tready = (r_state == S_IDLE) && i_status.out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser && !i_status.n_zero) begin
                        o_cmd.latch_in = 1'b1;
                        n_state        = S_SUM;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                if (i_status.sum_last) begin
                    o_cmd.mod_init = 1'b1;
                    n_state        = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_en = 1'b1;
                if (i_status.mod_last) begin
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                if (i_status.out_free) begin
                    o_cmd.step        = 1'b1;
                    o_cmd.src_latched = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/rkbc_datapath.sv =====
// Datapath: configuration registers, key byte select, sum and remainder units, output register.
`timescale 1ns / 1ps

module rkbc_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [rkbc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rkbc_pkg::KEY_WORD_W-1:0]      i_cfg_data,
    input  logic [rkbc_pkg::DATA_W-1:0]          i_data,
    input  logic                                 i_start,
    input  logic                                 i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [rkbc_pkg::DATA_W-1:0]          o_m_tdata,
    input  rkbc_pkg::t_cmd                       i_cmd,
    output rkbc_pkg::t_status                    o_status
);

    logic                                              r_decrypt;
    logic                                              r_cumulative;
    logic [rkbc_pkg::LEN_W-1:0]                        r_key_len;
    logic [rkbc_pkg::KEY_WORDS-1:0][rkbc_pkg::KEY_WORD_W-1:0] r_key;

    logic [rkbc_pkg::POS_W-1:0]  r_pos;
    logic [rkbc_pkg::DATA_W-1:0] r_off;
    logic [rkbc_pkg::DATA_W-1:0] r_data;
    logic [rkbc_pkg::POS_W-1:0]  r_idx;
    logic [rkbc_pkg::SUM_W-1:0]  r_sum;
    logic [rkbc_pkg::BIT_W-1:0]  r_bit;
    logic [rkbc_pkg::LEN_W-1:0]  r_rem;
    logic                        r_out_valid;
    logic [rkbc_pkg::DATA_W-1:0] r_out;

    logic [rkbc_pkg::LEN_W-1:0]  w_n;
    logic [rkbc_pkg::POS_W-1:0]  w_base_pos;
    logic [rkbc_pkg::DATA_W-1:0] w_base_off;
    logic [rkbc_pkg::POS_W-1:0]  w_pos_eff;
    logic [rkbc_pkg::POS_W-1:0]  w_addr;
    logic [rkbc_pkg::DATA_W-1:0] w_kb;
    logic [rkbc_pkg::DATA_W-1:0] w_step_data;
    logic                        w_step_start;
    logic [rkbc_pkg::DATA_W-1:0] w_off_new;
    logic [rkbc_pkg::DATA_W-1:0] w_res;
    logic [rkbc_pkg::LEN_W-1:0]  w_pinc;
    logic [rkbc_pkg::POS_W-1:0]  w_pos_next;
    logic [rkbc_pkg::LEN_W:0]    w_shift;
    logic [rkbc_pkg::LEN_W:0]    w_rem_full;

    assign w_n = (r_key_len > rkbc_pkg::LEN_W'(rkbc_pkg::KEY_MAX_BYTES))
               ? rkbc_pkg::LEN_W'(rkbc_pkg::KEY_MAX_BYTES) : r_key_len;

    assign w_base_pos = i_cmd.src_latched ? r_rem[rkbc_pkg::POS_W-1:0] : r_pos;
    assign w_base_off = i_cmd.src_latched ? rkbc_pkg::DATA_W'(r_rem) : r_off;
    assign w_pos_eff  = ({1'b0, w_base_pos} >= w_n) ? '0 : w_base_pos;

    assign w_addr = i_cmd.sum_en ? r_idx : w_pos_eff;
    assign w_kb   = r_key[w_addr[4:3]][{w_addr[2:0], 3'b000} +: rkbc_pkg::DATA_W];

    assign w_step_data  = i_cmd.src_latched ? r_data : i_data;
    assign w_step_start = i_cmd.src_latched ? 1'b0 : i_start;
    assign w_off_new    = r_cumulative ? (w_base_off + w_kb) : w_kb;
    assign w_res        = r_decrypt ? (w_step_data - w_off_new) : (w_step_data + w_off_new);
    assign w_pinc       = {1'b0, w_pos_eff} + rkbc_pkg::LEN_W'(1);
    assign w_pos_next   = (w_pinc == w_n) ? '0 : w_pinc[rkbc_pkg::POS_W-1:0];

    assign w_shift    = {r_rem, r_sum[r_bit]};
    assign w_rem_full = (w_shift >= {1'b0, w_n}) ? (w_shift - {1'b0, w_n}) : w_shift;

    assign o_status.n_zero   = (w_n == '0);
    assign o_status.sum_last = ({1'b0, r_idx} == (w_n - rkbc_pkg::LEN_W'(1)));
    assign o_status.mod_last = (r_bit == '0);
    assign o_status.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt    <= 1'b1;
            r_cumulative <= 1'b1;
            r_key_len    <= '0;
            r_key        <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rkbc_pkg::CFG_DECRYPT:    r_decrypt    <= i_cfg_data[0];
                rkbc_pkg::CFG_CUMULATIVE: r_cumulative <= i_cfg_data[0];
                rkbc_pkg::CFG_KEY_LENGTH: r_key_len    <= i_cfg_data[rkbc_pkg::LEN_W-1:0];
                rkbc_pkg::CFG_KEY_0_7:    r_key[0]     <= i_cfg_data;
                rkbc_pkg::CFG_KEY_8_15:   r_key[1]     <= i_cfg_data;
                rkbc_pkg::CFG_KEY_16_23:  r_key[2]     <= i_cfg_data;
                rkbc_pkg::CFG_KEY_24_31:  r_key[3]     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_off       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
                if (o_status.n_zero) begin
                    r_out <= w_step_data;
                    if (w_step_start) begin
                        r_pos <= '0;
                        r_off <= '0;
                    end
                end else begin
                    r_out <= w_res;
                    r_off <= w_off_new;
                    r_pos <= w_pos_next;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_data <= i_data;
            r_idx  <= '0;
            r_sum  <= '0;
        end
        if (i_cmd.sum_en) begin
            r_sum <= r_sum + rkbc_pkg::SUM_W'(w_kb);
            r_idx <= r_idx + rkbc_pkg::POS_W'(1);
        end
        if (i_cmd.mod_init) begin
            r_rem <= '0;
            r_bit <= rkbc_pkg::BIT_W'(rkbc_pkg::SUM_W - 1);
        end
        if (i_cmd.mod_en) begin
            r_rem <= w_rem_full[rkbc_pkg::LEN_W-1:0];
            r_bit <= r_bit - rkbc_pkg::BIT_W'(1);
        end
    end

    a_step_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> o_status.out_free)
        else $error("result register overwritten while pending");

    a_sum_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sum_en |-> !o_status.n_zero)
        else $error("key sum running with zero key length");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mod_en && o_status.mod_last) |=> (r_rem < w_n))
        else $error("remainder not below key length");

endmodule

// ===== tb/running_key_byte_cipher_unit_tb.sv =====
// Self-checking testbench for the running-key byte cipher: directed and random streams.
`timescale 1ns / 1ps

module running_key_byte_cipher_unit_tb;

    localparam logic [rkbc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int                             MAX_REPORTS = 10;

    class cipher_scoreboard;
        logic                            decrypt_q;
        logic                            cumulative_q;
        logic [rkbc_pkg::LEN_W-1:0]      key_len_q;
        logic [rkbc_pkg::KEY_WORD_W-1:0] key_word [rkbc_pkg::KEY_WORDS];
        logic [rkbc_pkg::POS_W-1:0]      pos_q;
        logic [rkbc_pkg::DATA_W-1:0]     offset_q;
        logic [rkbc_pkg::DATA_W-1:0]     expected_bytes [$];
        int unsigned                     mismatches;

        function new();
            decrypt_q    = 1'b1;
            cumulative_q = 1'b1;
            key_len_q    = '0;
            foreach (key_word[w]) key_word[w] = '0;
            pos_q        = '0;
            offset_q     = '0;
            mismatches   = 0;
        endfunction

        function logic [rkbc_pkg::DATA_W-1:0] key_at(int idx);
            return key_word[idx / 8][(idx % 8) * 8 +: 8];
        endfunction

        function void write_reg(logic [rkbc_pkg::CFG_IDX_W-1:0] idx,
                                logic [rkbc_pkg::KEY_WORD_W-1:0] value);
            case (idx)
                rkbc_pkg::CFG_DECRYPT:    decrypt_q    = value[0];
                rkbc_pkg::CFG_CUMULATIVE: cumulative_q = value[0];
                rkbc_pkg::CFG_KEY_LENGTH: key_len_q    = value[rkbc_pkg::LEN_W-1:0];
                rkbc_pkg::CFG_KEY_0_7:    key_word[0]  = value;
                rkbc_pkg::CFG_KEY_8_15:   key_word[1]  = value;
                rkbc_pkg::CFG_KEY_16_23:  key_word[2]  = value;
                rkbc_pkg::CFG_KEY_24_31:  key_word[3]  = value;
                default: ;
            endcase
        endfunction

        function void note_byte(logic [rkbc_pkg::DATA_W-1:0] value, logic sos);
            int n;
            int sum;
            int p;
            n = (key_len_q > rkbc_pkg::KEY_MAX_BYTES) ? rkbc_pkg::KEY_MAX_BYTES
                                                       : int'(key_len_q);
            if (n == 0) begin
                if (sos) begin
                    pos_q    = '0;
                    offset_q = '0;
                end
                expected_bytes.push_back(value);
            end else begin
                if (sos) begin
                    sum = 0;
                    for (int i = 0; i < n; i++) sum += key_at(i);
                    sum      = sum % n;
                    pos_q    = sum[rkbc_pkg::POS_W-1:0];
                    offset_q = sum[rkbc_pkg::DATA_W-1:0];
                end
                p = pos_q;
                if (p >= n) p = 0;
                if (cumulative_q) offset_q = offset_q + key_at(p);
                else offset_q = key_at(p);
                pos_q = rkbc_pkg::POS_W'((p + 1) % n);
                expected_bytes.push_back(decrypt_q ? value - offset_q : value + offset_q);
            end
        endfunction

        function void flag(string what, logic [rkbc_pkg::DATA_W-1:0] want,
                           logic [rkbc_pkg::DATA_W-1:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t ns: %s: expected 0x%02h, got 0x%02h", $time, what, want, got);
        endfunction

        function void check_byte(logic [rkbc_pkg::DATA_W-1:0] actual);
            logic [rkbc_pkg::DATA_W-1:0] want;
            if (expected_bytes.size() == 0) begin
                flag("output with nothing outstanding", 'x, actual);
            end else begin
                want = expected_bytes.pop_front();
                if (actual !== want) flag("data_out mismatch", want, actual);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [7:0]                      i_s_tdata;
    logic                            i_s_tuser;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [7:0]                      o_m_tdata;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [rkbc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rkbc_pkg::KEY_WORD_W-1:0] i_cfg_data;

    cipher_scoreboard sb;
    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;
    int unsigned      bytes_sent;
    int unsigned      starts_sent;
    int unsigned      settings_loaded;

    running_key_byte_cipher_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic send_byte(input logic [7:0] value, input logic sos);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= sos;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_byte(value, sos);
        bytes_sent++;
        if (sos) starts_sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rkbc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rkbc_pkg::KEY_WORD_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    task automatic load_setting(input logic dec, input logic cum,
                                input logic [rkbc_pkg::LEN_W-1:0] len,
                                input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] k2, input logic [63:0] k3);
        write_reg(rkbc_pkg::CFG_DECRYPT, rkbc_pkg::KEY_WORD_W'(dec));
        write_reg(rkbc_pkg::CFG_CUMULATIVE, rkbc_pkg::KEY_WORD_W'(cum));
        write_reg(rkbc_pkg::CFG_KEY_LENGTH, rkbc_pkg::KEY_WORD_W'(len));
        write_reg(rkbc_pkg::CFG_KEY_0_7, k0);
        write_reg(rkbc_pkg::CFG_KEY_8_15, k1);
        write_reg(rkbc_pkg::CFG_KEY_16_23, k2);
        write_reg(rkbc_pkg::CFG_KEY_24_31, k3);
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    function automatic logic [63:0] key_word_pick();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_segment();
        logic [rkbc_pkg::LEN_W-1:0] len;
        int unsigned                count;
        case ($urandom_range(9))
            0:       len = '0;
            1:       len = rkbc_pkg::LEN_W'(rkbc_pkg::KEY_MAX_BYTES);
            2:       len = rkbc_pkg::LEN_W'($urandom_range(63, rkbc_pkg::KEY_MAX_BYTES + 1));
            3:       len = rkbc_pkg::LEN_W'($urandom_range(63));
            default: len = rkbc_pkg::LEN_W'($urandom_range(8, 1));
        endcase
        drain();
        load_setting(1'($urandom_range(1)), 1'($urandom_range(1)), len, key_word_pick(),
                     key_word_pick(), key_word_pick(), key_word_pick());
        count = $urandom_range(40, 10);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2 && $urandom_range(3) == 0) drain();
            send_byte(8'($urandom_range(255)),
                      (i == 0) ? ($urandom_range(7) != 0) : ($urandom_range(19) == 0));
        end
    endtask

    initial begin
        @(posedge i_clk);
        forever begin
            if (i_rst_n && i_m_tready && o_m_tvalid) sb.check_byte(o_m_tdata);
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge i_clk);
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL running_key_byte_cipher_unit");
        $finish;
    end

    initial begin
        sb              = new();
        i_rst_n         = 1'b0;
        i_s_tvalid      = 1'b0;
        i_s_tdata       = '0;
        i_s_tuser       = 1'b0;
        i_m_tready      = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        send_idle_pct   = 22;
        recv_idle_pct   = 85;
        bytes_sent      = 0;
        starts_sent     = 0;
        settings_loaded = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass-through at reset values
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        drain();

        // plain encode, short key, first byte without start
        load_setting(1'b0, 1'b0, 6'd3, 64'h0000_0000_0080_FF01, '0, '0, '0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        drain();

        // full key of 0xFF, cumulative decode
        load_setting(1'b1, 1'b1, 6'd32, '1, '1, '1, '1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        drain();

        // oversized length saturates
        load_setting(1'b0, 1'b1, 6'd63, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908,
                     64'h1716_1514_1312_1110, 64'h1F1E_1D1C_1B1A_1918);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h01, 1'b0);
        drain();

        // shorten the key mid-stream: position falls past the end
        load_setting(1'b1, 1'b0, 6'd5, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908,
                     64'h1716_1514_1312_1110, 64'h1F1E_1D1C_1B1A_1918);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        drain();

        // zero length with a start clears the state
        load_setting(1'b1, 1'b1, 6'd0, 64'h0706_0504_0302_0100, '0, '0, '1);
        send_byte(8'h44, 1'b0);
        send_byte(8'h99, 1'b1);
        send_byte(8'hE7, 1'b0);
        drain();
        load_setting(1'b0, 1'b1, 6'd1, 64'h0000_0000_0000_00C9, '0, '0, '0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);

        while (bytes_sent < 240) random_segment();
        drain();
        send_idle_pct = 85;
        recv_idle_pct = 22;
        while (bytes_sent < 440) random_segment();
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (bytes_sent < 630) random_segment();

        drain();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d bytes with %0d stream starts over %0d key settings,",
                 bytes_sent, starts_sent, settings_loaded);
        $display("under three back-pressure profiles; %0d mismatches.", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS running_key_byte_cipher_unit");
        end else begin
            $display("FAIL running_key_byte_cipher_unit");
        end
        $finish;
    end

endmodule
